// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- sv/fdtd_pkg.sv -----
// package for the fdtd component update: constants, types, helpers
// no dependencies
`timescale 1ns / 1ps
package fdtd_pkg;
	localparam int MaxNx = 64;
	localparam int MaxNy = 64;
	localparam int MaxNz = 64;
	localparam int ValueWidth = 32;
	localparam int FracBits = 24;
	localparam int PosW = $clog2(MaxNx);
	localparam int PosWy = $clog2(MaxNy);
	localparam int PosWz = $clog2(MaxNz);
	localparam int PlaneDepth = MaxNy * MaxNz;
	localparam int PlaneAw = $clog2(PlaneDepth);
	localparam int SizeW = 7;
	localparam int CfgIdxW = 3;
	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);

	typedef enum logic [CfgIdxW-1:0] {
		REG_COMPONENT = 3'd0, REG_SIZE_X = 3'd1, REG_SIZE_Y = 3'd2, REG_SIZE_Z = 3'd3,
		REG_GAIN = 3'd4, REG_COEF_X = 3'd5, REG_COEF_Y = 3'd6, REG_COEF_Z = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		COMP_HX = 3'd0, COMP_HY = 3'd1, COMP_HZ = 3'd2,
		COMP_EX = 3'd3, COMP_EY = 3'd4, COMP_EZ = 3'd5
	} comp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_MUL, ST_CURL, ST_GAIN, ST_SUM, ST_OUT
	} back_st_t;

	typedef logic signed [ValueWidth-1:0] value_t;

	// item after classification, handed from front to back
	typedef struct packed {
		value_t own;
		value_t a;
		value_t b;
		logic [PosWz-1:0] z;
		logic [PlaneAw-1:0] pidx;
		logic [1:0] axis;
		logic h;
		logic inb;
		logic done;
	} task_t;

	typedef struct packed {
		value_t new_value;
		logic was_updated;
		logic saturated;
		logic grid_done;
	} result_t;

	function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] s,
			input logic [SizeW-1:0] mx);
		logic [SizeW-1:0] r;
		begin
			r = s;
			if (s < SizeW'(2)) r = SizeW'(2);
			else if (s > mx) r = mx;
			return r;
		end
	endfunction
endpackage

// ----- sv/fdtd_if.sv -----
// valid/ready channel interfaces for the fdtd block
// depends on fdtd_pkg
`timescale 1ns / 1ps
interface fdtd_cell_if;
	logic valid;
	logic ready;
	fdtd_pkg::value_t cell_own;
	fdtd_pkg::value_t src_a;
	fdtd_pkg::value_t src_b;
	modport source(output valid, cell_own, src_a, src_b, input ready);
	modport sink(input valid, cell_own, src_a, src_b, output ready);
endinterface

interface fdtd_result_if;
	logic valid;
	logic ready;
	fdtd_pkg::value_t new_value;
	logic was_updated;
	logic saturated;
	logic grid_done;
	modport source(output valid, new_value, was_updated, saturated, grid_done, input ready);
	modport sink(input valid, new_value, was_updated, saturated, grid_done, output ready);
endinterface

interface fdtd_cfg_if;
	logic valid;
	logic ready;
	logic [fdtd_pkg::CfgIdxW-1:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/fdtd_ram.sv -----
// generic single-port-write, one-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module fdtd_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/fdtd_front.sv -----
// front: walks the sweep position and classifies each item
// depends on fdtd_pkg, fdtd_if
`timescale 1ns / 1ps
module fdtd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	fdtd_cell_if.sink                       node,
	input  logic [2:0]                      component,
	input  logic [fdtd_pkg::SizeW-1:0]      nx,
	input  logic [fdtd_pkg::SizeW-1:0]      ny,
	input  logic [fdtd_pkg::SizeW-1:0]      nz,
	input  logic                            restart,
	input  logic                            q_full,
	output logic                            push,
	output fdtd_pkg::task_t                 push_task
);
	logic [fdtd_pkg::PosW-1:0] x_q;
	logic [fdtd_pkg::PosWy-1:0] y_q;
	logic [fdtd_pkg::PosWz-1:0] z_q;
	logic h;
	logic [fdtd_pkg::PosW-1:0] xl, xm;
	logic [fdtd_pkg::PosWy-1:0] yl, ym;
	logic [fdtd_pkg::PosWz-1:0] zl, zm;
	logic at_end;

	assign h = (component <= 3'(fdtd_pkg::COMP_HZ));
	assign xm = fdtd_pkg::PosW'(nx - 7'd1);
	assign ym = fdtd_pkg::PosWy'(ny - 7'd1);
	assign zm = fdtd_pkg::PosWz'(nz - 7'd1);
	assign xl = (x_q > xm) ? xm : x_q;
	assign yl = (y_q > ym) ? ym : y_q;
	assign zl = (z_q > zm) ? zm : z_q;

	assign node.ready = !q_full;
	assign push = node.valid && node.ready;

	always_comb begin
		push_task.own = node.cell_own;
		push_task.a = node.src_a;
		push_task.b = node.src_b;
		push_task.z = zl;
		push_task.pidx = {yl, zl};
		push_task.h = h;
		case (component)
			3'(fdtd_pkg::COMP_HX), 3'(fdtd_pkg::COMP_EX): push_task.axis = 2'd0;
			3'(fdtd_pkg::COMP_HY), 3'(fdtd_pkg::COMP_EY): push_task.axis = 2'd1;
			default: push_task.axis = 2'd2;
		endcase
		if (h) begin
			push_task.inb = (xl != xm) && (yl != ym) && (zl != zm);
			at_end = (xl == '0) && (yl == '0) && (zl == '0);
		end else begin
			push_task.inb = (xl != '0) && (yl != '0) && (zl != '0)
				&& (component <= 3'(fdtd_pkg::COMP_EZ));
			at_end = (xl == xm) && (yl == ym) && (zl == zm);
		end
		push_task.done = at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= fdtd_pkg::PosW'(1);
			y_q <= fdtd_pkg::PosWy'(1);
			z_q <= fdtd_pkg::PosWz'(1);
		end else if (restart) begin
			x_q <= h ? xm : '0;
			y_q <= h ? ym : '0;
			z_q <= h ? zm : '0;
		end else if (push) begin
			if (h) begin
				if (zl != '0) z_q <= zl - 1'b1;
				else begin
					z_q <= zm;
					if (yl != '0) y_q <= yl - 1'b1;
					else begin
						y_q <= ym;
						x_q <= (xl != '0) ? xl - 1'b1 : xm;
					end
				end
			end else begin
				if (zl != zm) z_q <= zl + 1'b1;
				else begin
					z_q <= '0;
					if (yl != ym) y_q <= yl + 1'b1;
					else begin
						y_q <= '0;
						x_q <= (xl != xm) ? xl + 1'b1 : '0;
					end
				end
			end
		end
	end
endmodule

// ----- sv/fdtd_queue.sv -----
// short fifo between front and back
// depends on fdtd_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fdtd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fdtd_pkg::task_t push_task,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output fdtd_pkg::task_t head
);
	fdtd_pkg::task_t buf_q [fdtd_pkg::QDepth];
	logic [fdtd_pkg::QAw-1:0] wp_q, rp_q;
	logic [fdtd_pkg::QAw:0] cnt_q;

	assign full = (cnt_q == (fdtd_pkg::QAw+1)'(fdtd_pkg::QDepth));
	assign not_empty = (cnt_q != '0);
	assign head = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= push_task;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (fdtd_pkg::QAw+1)'(push) - (fdtd_pkg::QAw+1)'(pop);
		end
	end

	`ASSERT_IMPL(a_no_overflow, clk, arst_n, full, !push)
	`ASSERT_IMPL(a_no_underflow, clk, arst_n, !not_empty, !pop)
endmodule

// ----- sv/fdtd_back.sv -----
// back: neighbour buffers, curl arithmetic, saturation and output register
// depends on fdtd_pkg, fdtd_if, fdtd_ram, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fdtd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                not_empty,
	input  fdtd_pkg::task_t     head,
	output logic                pop,
	input  fdtd_pkg::value_t    field_gain,
	input  fdtd_pkg::value_t    coef_x,
	input  fdtd_pkg::value_t    coef_y,
	input  fdtd_pkg::value_t    coef_z,
	fdtd_result_if.source       res
);
	// reads buffers, differences, curl products, clipped curl, gain mult, sum
	localparam int W = fdtd_pkg::ValueWidth;
	localparam int F = fdtd_pkg::FracBits;
	localparam int SW = 2*W - F + 1;
	fdtd_pkg::back_st_t st_q, st_d;

	fdtd_pkg::task_t t_q;
	logic signed [W-1:0] prev_a_q, prev_b_q;
	logic [W-1:0] ra_rd, rb_rd, pa_rd, pb_rd;
	logic signed [W:0] da_s2, db_s2;
	logic signed [W-1:0] c1_s2, c2_s2;
	logic signed [2*W+1:0] p1_s3, p2_s3;
	logic signed [W-1:0] curl_s4;
	logic clip_q;
	logic signed [2*W-1:0] g_s5;
	fdtd_pkg::result_t out_q;
	logic out_v_q;
	logic write_buf;

	assign pop = (st_q == fdtd_pkg::ST_IDLE) && not_empty && !out_v_q;
	assign write_buf = (st_q == fdtd_pkg::ST_RD);

	fdtd_ram #(.Width(W), .Depth(fdtd_pkg::MaxNz)) u_row_a (.clk, .we(write_buf),
		.waddr(t_q.z), .wdata(t_q.a), .re(pop), .raddr(head.z), .rdata(ra_rd));
	fdtd_ram #(.Width(W), .Depth(fdtd_pkg::MaxNz)) u_row_b (.clk, .we(write_buf),
		.waddr(t_q.z), .wdata(t_q.b), .re(pop), .raddr(head.z), .rdata(rb_rd));
	fdtd_ram #(.Width(W), .Depth(fdtd_pkg::PlaneDepth)) u_plane_a (.clk, .we(write_buf),
		.waddr(t_q.pidx), .wdata(t_q.a), .re(pop), .raddr(head.pidx), .rdata(pa_rd));
	fdtd_ram #(.Width(W), .Depth(fdtd_pkg::PlaneDepth)) u_plane_b (.clk, .we(write_buf),
		.waddr(t_q.pidx), .wdata(t_q.b), .re(pop), .raddr(head.pidx), .rdata(pb_rd));

	always_comb begin
		st_d = st_q;
		case (st_q)
			fdtd_pkg::ST_IDLE: if (pop) st_d = fdtd_pkg::ST_RD;
			fdtd_pkg::ST_RD: st_d = fdtd_pkg::ST_MUL;
			fdtd_pkg::ST_MUL: st_d = fdtd_pkg::ST_CURL;
			fdtd_pkg::ST_CURL: st_d = fdtd_pkg::ST_GAIN;
			fdtd_pkg::ST_GAIN: st_d = fdtd_pkg::ST_SUM;
			fdtd_pkg::ST_SUM: st_d = fdtd_pkg::ST_OUT;
			fdtd_pkg::ST_OUT: st_d = fdtd_pkg::ST_IDLE;
			default: st_d = fdtd_pkg::ST_IDLE;
		endcase
	end

	logic signed [W-1:0] an, bn;
	logic signed [2*W+1:0] p1_f, p2_f;
	logic signed [2*W+2:0] cdiff;
	logic signed [2*W-1:0] gs;
	logic signed [SW-1:0] sum;
	always_comb begin
		case (t_q.axis)
			2'd0: begin an = prev_a_q; bn = $signed(rb_rd); end
			2'd1: begin an = $signed(pa_rd); bn = prev_b_q; end
			default: begin an = $signed(ra_rd); bn = $signed(pb_rd); end
		endcase
		p1_f = p1_s3 >>> F;
		p2_f = p2_s3 >>> F;
		cdiff = {p1_f[2*W+1], p1_f} - {p2_f[2*W+1], p2_f};
		gs = g_s5 >>> F;
		sum = {{(SW-W){t_q.own[W-1]}}, t_q.own} + gs[SW-1:0];
	end

	always_ff @(posedge clk) begin
		case (st_q)
			fdtd_pkg::ST_IDLE: if (pop) t_q <= head;
			fdtd_pkg::ST_MUL: begin
				prev_a_q <= t_q.a;
				prev_b_q <= t_q.b;
				if (t_q.h) begin
					da_s2 <= {an[W-1], an} - {t_q.a[W-1], t_q.a};
					db_s2 <= {bn[W-1], bn} - {t_q.b[W-1], t_q.b};
				end else begin
					da_s2 <= {t_q.a[W-1], t_q.a} - {an[W-1], an};
					db_s2 <= {t_q.b[W-1], t_q.b} - {bn[W-1], bn};
				end
				case (t_q.axis)
					2'd0: begin c1_s2 <= coef_z; c2_s2 <= coef_y; end
					2'd1: begin c1_s2 <= coef_x; c2_s2 <= coef_z; end
					default: begin c1_s2 <= coef_y; c2_s2 <= coef_x; end
				endcase
			end
			fdtd_pkg::ST_CURL: begin
				p1_s3 <= (2*W+2)'(da_s2 * c1_s2);
				p2_s3 <= (2*W+2)'(db_s2 * c2_s2);
			end
			fdtd_pkg::ST_GAIN: begin
				clip_q <= 1'b0;
				if (cdiff > $signed((2*W+3)'({1'b0, {(W-1){1'b1}}}))) begin
					curl_s4 <= {1'b0, {(W-1){1'b1}}}; clip_q <= 1'b1;
				end else if (cdiff < -$signed((2*W+3)'({1'b1, {(W-1){1'b0}}}))) begin
					curl_s4 <= {1'b1, {(W-1){1'b0}}}; clip_q <= 1'b1;
				end else curl_s4 <= cdiff[W-1:0];
			end
			fdtd_pkg::ST_SUM: g_s5 <= field_gain * curl_s4;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fdtd_pkg::ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res.valid && res.ready) out_v_q <= 1'b0;
			if (st_q == fdtd_pkg::ST_OUT) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == fdtd_pkg::ST_OUT) begin
			out_q.grid_done <= t_q.done;
			out_q.was_updated <= t_q.inb;
			if (!t_q.inb) begin
				out_q.new_value <= t_q.own;
				out_q.saturated <= 1'b0;
			end else if (sum > $signed(SW'({1'b0, {(W-1){1'b1}}}))) begin
				out_q.new_value <= {1'b0, {(W-1){1'b1}}}; out_q.saturated <= 1'b1;
			end else if (sum < -$signed(SW'({1'b1, {(W-1){1'b0}}}))) begin
				out_q.new_value <= {1'b1, {(W-1){1'b0}}}; out_q.saturated <= 1'b1;
			end else begin
				out_q.new_value <= sum[W-1:0]; out_q.saturated <= clip_q;
			end
		end
	end

	assign res.valid = out_v_q;
	assign res.new_value = out_q.new_value;
	assign res.was_updated = out_q.was_updated;
	assign res.saturated = out_q.saturated;
	assign res.grid_done = out_q.grid_done;

	`ASSERT_NEXT(a_out_after_work, clk, arst_n, st_q == fdtd_pkg::ST_OUT, out_v_q)
	`ASSERT_IMPL(a_no_pop_busy, clk, arst_n, st_q != fdtd_pkg::ST_IDLE, !pop)
endmodule

// ----- sv/fdtd_yee_field_component_update.sv -----
// channel    dir  contents
// node       in   cell_own, src_a, src_b
// result     out  new_value, was_updated, saturated, grid_done
// cfg        in   index, data
// the back takes one item at a time: it runs read, two multiply stages, curl and sum in turn
// a 4-entry queue lets the front take items while the back works
// arst_n clears state; buffers are undefined until written
// component/size writes restart the sweep position; a held result blocks back, then front
`timescale 1ns / 1ps
module fdtd_yee_field_component_update (
	input logic clk,
	input logic arst_n,
	fdtd_cell_if.sink node,
	fdtd_result_if.source res,
	fdtd_cfg_if.sink cfg
);
	logic [2:0] component_q;
	logic [fdtd_pkg::SizeW-1:0] sx_q, sy_q, sz_q, nx, ny, nz;
	fdtd_pkg::value_t gain_q, cx_q, cy_q, cz_q;
	logic restart, push, q_full, pop, not_empty;
	fdtd_pkg::task_t push_task, head;

	assign cfg.ready = 1'b1;
	assign restart = cfg.valid && (cfg.index == fdtd_pkg::REG_COMPONENT
		|| cfg.index == fdtd_pkg::REG_SIZE_X || cfg.index == fdtd_pkg::REG_SIZE_Y
		|| cfg.index == fdtd_pkg::REG_SIZE_Z);

	// restart uses the new value: apply it combinationally on the write cycle
	logic [2:0] comp_n;
	always_comb begin
		comp_n = component_q;
		nx = fdtd_pkg::eff_size(sx_q, 7'(fdtd_pkg::MaxNx));
		ny = fdtd_pkg::eff_size(sy_q, 7'(fdtd_pkg::MaxNy));
		nz = fdtd_pkg::eff_size(sz_q, 7'(fdtd_pkg::MaxNz));
		if (cfg.valid) begin
			case (cfg.index)
				fdtd_pkg::REG_COMPONENT: comp_n = cfg.data[2:0];
				fdtd_pkg::REG_SIZE_X: nx = fdtd_pkg::eff_size(cfg.data[6:0], 7'(fdtd_pkg::MaxNx));
				fdtd_pkg::REG_SIZE_Y: ny = fdtd_pkg::eff_size(cfg.data[6:0], 7'(fdtd_pkg::MaxNy));
				fdtd_pkg::REG_SIZE_Z: nz = fdtd_pkg::eff_size(cfg.data[6:0], 7'(fdtd_pkg::MaxNz));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			component_q <= '0;
			sx_q <= 7'd2; sy_q <= 7'd2; sz_q <= 7'd2;
			gain_q <= '0; cx_q <= '0; cy_q <= '0; cz_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				fdtd_pkg::REG_COMPONENT: component_q <= cfg.data[2:0];
				fdtd_pkg::REG_SIZE_X: sx_q <= cfg.data[6:0];
				fdtd_pkg::REG_SIZE_Y: sy_q <= cfg.data[6:0];
				fdtd_pkg::REG_SIZE_Z: sz_q <= cfg.data[6:0];
				fdtd_pkg::REG_GAIN: gain_q <= cfg.data;
				fdtd_pkg::REG_COEF_X: cx_q <= cfg.data;
				fdtd_pkg::REG_COEF_Y: cy_q <= cfg.data;
				fdtd_pkg::REG_COEF_Z: cz_q <= cfg.data;
				default: ;
			endcase
		end
	end

	fdtd_front u_front (.clk, .arst_n, .node, .component(comp_n), .nx, .ny, .nz,
		.restart, .q_full, .push, .push_task);
	fdtd_queue u_queue (.clk, .arst_n, .push, .push_task, .full(q_full), .pop,
		.not_empty, .head);
	fdtd_back u_back (.clk, .arst_n, .not_empty, .head, .pop, .field_gain(gain_q),
		.coef_x(cx_q), .coef_y(cy_q), .coef_z(cz_q), .res);
endmodule
